/* rtl/core/hgssd_pkg.sv */
// Shared types, constants and the hue-match helper function of the hue-gated saturation surge detector.
package hgssd_pkg;

   localparam int WINDOW_DEPTH_DEF = 16;

   localparam int HUE_W    = 9;
   localparam int SAT_W    = 8;
   localparam int TIME_W   = 32;
   localparam int CNT_W    = 4;
   localparam int GAIN_W   = 16;
   localparam int RUN_W    = 4;
   localparam int SUM_W    = 48;
   localparam int PROD_W   = SAT_W + TIME_W;
   localparam int HALF_W   = SUM_W / 2;
   localparam int MUL_W    = GAIN_W + HALF_W;
   localparam int CMP_W    = GAIN_W + SUM_W;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 4;

   localparam logic [HUE_W-1:0]  TARGET_RST = 9'd204;
   localparam logic [CNT_W-1:0]  COUNT_RST  = 4'd5;
   localparam logic [GAIN_W-1:0] GAIN_RST   = 16'd1024;
   localparam logic [RUN_W-1:0]  RUN_MAX    = 4'd15;

   localparam logic [ADDR_W-1:0] ADDR_TARGET = 4'h0;
   localparam logic [ADDR_W-1:0] ADDR_COUNT  = 4'h4;
   localparam logic [ADDR_W-1:0] ADDR_GAIN   = 4'h8;

   localparam logic [HUE_W:0] HUE_MOD  = 10'd360;
   localparam logic [HUE_W:0] HUE_SPAN = 10'd30;

   typedef struct packed {
      logic [SAT_W-1:0]  sat;
      logic [TIME_W-1:0] stamp;
   } sample_type;

   typedef struct packed {
      logic load;
      logic shift;
      logic accum;
   } cell_ctl_type;

   function automatic logic hue_match(input logic [HUE_W-1:0] hue,
                                      input logic [HUE_W-1:0] ctr);
      logic [HUE_W:0] h;
      logic [HUE_W:0] c;
      logic [HUE_W:0] d;
      h = ({1'b0, hue} >= HUE_MOD) ? {1'b0, hue} - HUE_MOD : {1'b0, hue};
      c = ({1'b0, ctr} >= HUE_MOD) ? {1'b0, ctr} - HUE_MOD : {1'b0, ctr};
      d = (h >= c) ? h - c : h + HUE_MOD - c;
      return (d < HUE_SPAN) || (d > (HUE_MOD - HUE_SPAN));
   endfunction

endpackage

/* rtl/core/hgssd_cell.sv */
// One window cell: holds a sample, forms its weighted interval and passes a partial sum on.
module hgssd_cell (
   input  logic                                  clock,
   input  hgssd_pkg::cell_ctl_type               ctl,
   input  hgssd_pkg::sample_type                 new_sample,
   input  hgssd_pkg::sample_type                 next_sample,
   input  logic [hgssd_pkg::TIME_W-1:0]          prev_time,
   input  logic [hgssd_pkg::SUM_W-1:0]           psum_prev,
   output hgssd_pkg::sample_type                 sample,
   output logic [hgssd_pkg::SUM_W-1:0]           psum
);

   hgssd_pkg::sample_type               sample_ff, sample_in;
   logic [hgssd_pkg::PROD_W-1:0]        prod_ff, prod_in;
   logic [hgssd_pkg::SUM_W-1:0]         psum_ff, psum_in;
   logic [hgssd_pkg::TIME_W-1:0]        dt;

   always_comb begin
      if (ctl.load) begin
         sample_in = new_sample;
      end else if (ctl.shift) begin
         sample_in = next_sample;
      end else begin
         sample_in = sample_ff;
      end
   end

   assign dt      = sample_ff.stamp - prev_time;
   assign prod_in = {{hgssd_pkg::TIME_W{1'b0}}, sample_ff.sat}
                  * {{hgssd_pkg::SAT_W{1'b0}}, dt};
   assign psum_in = psum_prev + (ctl.accum
                  ? {{(hgssd_pkg::SUM_W - hgssd_pkg::PROD_W){1'b0}}, prod_ff}
                  : {hgssd_pkg::SUM_W{1'b0}});

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      prod_ff   <= prod_in;
      psum_ff   <= psum_in;
   end

   assign sample = sample_ff;
   assign psum   = psum_ff;

endmodule

/* rtl/core/hue_gated_saturation_surge_detector_core.sv */
// Top level of the hue-gated saturation surge detector: control, registers and cell row.
//
// Usage:
//   Requests (hue, saturation, timestamp) enter on the req_ valid/ready channel; each
//   request yields exactly one rsp_surge_found result on the rsp_ valid/ready channel.
//   One request is worked on at a time. From acceptance to result the partial sum
//   walks the row of WINDOW_DEPTH cells one cell per cycle; then the minimum is
//   updated, the gain product formed and the comparison made. req_ready is high only
//   while no request is in work, so a new request is not taken until the previous one
//   has left the compare step. The result sits in an output register; the next
//   request is accepted while it waits. If the receiver stalls, the following result
//   holds in the compare step until the output register frees, and no further request
//   is taken meanwhile. Configuration registers (target_hue at 0x0, window_count at
//   0x4, gain_q8 at 0x8) are written over the APB-style port; the user must write them
//   only while the block is idle, which the block does not enforce. Reset restores
//   register defaults, empties the window, clears the hue run and sets the minimum sum
//   to all ones; the block is ready in the first cycle after reset.
module hue_gated_saturation_surge_detector_core #(
   parameter int WINDOW_DEPTH = hgssd_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [hgssd_pkg::HUE_W-1:0]           req_hue_deg,
   input  logic [hgssd_pkg::SAT_W-1:0]           req_sat_level,
   input  logic [hgssd_pkg::TIME_W-1:0]          req_time_us,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_surge_found,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [hgssd_pkg::ADDR_W-1:0]          paddr,
   input  logic [hgssd_pkg::DATA_W-1:0]          pwdata,
   output logic [hgssd_pkg::DATA_W-1:0]          prdata,
   output logic                                  pready
);

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int CW    = (IDX_W > hgssd_pkg::CNT_W) ? IDX_W : hgssd_pkg::CNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SUM  = 3'd1;
   localparam logic [2:0] ST_MIN  = 3'd2;
   localparam logic [2:0] ST_MUL  = 3'd3;
   localparam logic [2:0] ST_CMP  = 3'd4;

   logic [2:0]                          state_ff, state_in;
   logic [IDX_W-1:0]                    step_ff, step_in;
   logic [IDX_W-1:0]                    fill_ff, fill_in;
   logic [IDX_W-1:0]                    cnt_ff, cnt_in;
   logic [hgssd_pkg::RUN_W-1:0]         run_ff, run_in;
   logic [hgssd_pkg::SUM_W-1:0]         min_ff, min_in;
   logic [hgssd_pkg::SUM_W-1:0]         sum_ff, sum_in;
   logic [hgssd_pkg::MUL_W-1:0]         plo_ff, plo_in;
   logic [hgssd_pkg::MUL_W-1:0]         phi_ff, phi_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                found_ff, found_in;
   logic [hgssd_pkg::HUE_W-1:0]         target_ff, target_in;
   logic [hgssd_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [hgssd_pkg::GAIN_W-1:0]        gain_ff, gain_in;

   logic                                req_fire;
   logic                                csr_write;
   logic                                out_free;
   logic                                full;
   logic                                shift_go;
   logic [CW-1:0]                       cnt_wide;
   logic [IDX_W-1:0]                    cnt_eff;
   logic [IDX_W-1:0]                    fill_eff;
   logic [hgssd_pkg::CMP_W-1:0]         lhs;
   logic [hgssd_pkg::CMP_W-1:0]         rhs;
   logic [hgssd_pkg::SUM_W-1:0]         total;
   hgssd_pkg::sample_type               new_sample;

   hgssd_pkg::sample_type               cell_sample [WINDOW_DEPTH];
   logic [hgssd_pkg::SUM_W-1:0]         cell_psum   [WINDOW_DEPTH];
   hgssd_pkg::cell_ctl_type             cell_ctl    [WINDOW_DEPTH];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign full      = (fill_ff == cnt_ff);
   assign shift_go  = (state_ff == ST_CMP) && out_free && full;
   assign total     = cell_psum[WINDOW_DEPTH-1];

   assign new_sample.sat   = req_sat_level;
   assign new_sample.stamp = req_time_us;

   assign cnt_wide = (CW'(count_ff) > CW'(LAST_IDX)) ? CW'(LAST_IDX) : CW'(count_ff);
   assign cnt_eff  = cnt_wide[IDX_W-1:0];
   assign fill_eff = (fill_ff > cnt_eff) ? cnt_eff : fill_ff;

   assign lhs = {{(hgssd_pkg::CMP_W - hgssd_pkg::SUM_W - 8){1'b0}}, sum_ff, 8'b0};
   assign rhs = {phi_ff, {hgssd_pkg::HALF_W{1'b0}}}
              + {{(hgssd_pkg::CMP_W - hgssd_pkg::MUL_W){1'b0}}, plo_ff};

   // cell row
   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      hgssd_pkg::sample_type         next_s;
      logic [hgssd_pkg::TIME_W-1:0]  prev_t;
      logic [hgssd_pkg::SUM_W-1:0]   prev_s;

      if (i == 0) begin : g_head
         assign prev_t = '0;
         assign prev_s = '0;
      end else begin : g_body
         assign prev_t = cell_sample[i-1].stamp;
         assign prev_s = cell_psum[i-1];
      end

      if (i == WINDOW_DEPTH - 1) begin : g_tail
         assign next_s = '0;
      end else begin : g_mid
         assign next_s = cell_sample[i+1];
      end

      assign cell_ctl[i].load  = req_fire && (fill_eff == IDX_W'(i));
      assign cell_ctl[i].shift = shift_go && (IDX_W'(i) < fill_ff);
      assign cell_ctl[i].accum = (i != 0) && (IDX_W'(i) <= fill_ff);

      hgssd_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[i]),
         .new_sample  (new_sample),
         .next_sample (next_s),
         .prev_time   (prev_t),
         .psum_prev   (prev_s),
         .sample      (cell_sample[i]),
         .psum        (cell_psum[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      run_in       = run_ff;
      min_in       = min_ff;
      sum_in       = sum_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      found_in     = found_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in  = cnt_eff;
               fill_in = fill_eff;
               step_in = '0;
               if (hgssd_pkg::hue_match(req_hue_deg, target_ff)) begin
                  if (run_ff < hgssd_pkg::RUN_MAX) begin
                     run_in = run_ff + hgssd_pkg::RUN_W'(1);
                  end
               end else begin
                  run_in = '0;
               end
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            step_in = step_ff + IDX_W'(1);
            if (step_ff == LAST_IDX) begin
               state_in = ST_MIN;
            end
         end
         ST_MIN: begin
            sum_in = total;
            if ((fill_ff != '0) && (total < min_ff)) begin
               min_in = total;
            end
            state_in = ST_MUL;
         end
         ST_MUL: begin
            plo_in = {{hgssd_pkg::HALF_W{1'b0}}, gain_ff}
                   * {{hgssd_pkg::GAIN_W{1'b0}}, min_ff[hgssd_pkg::HALF_W-1:0]};
            phi_in = {{hgssd_pkg::HALF_W{1'b0}}, gain_ff}
                   * {{hgssd_pkg::GAIN_W{1'b0}},
                      min_ff[hgssd_pkg::SUM_W-1:hgssd_pkg::HALF_W]};
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (out_free) begin
               found_in     = full && (min_ff != '0) && (lhs > rhs)
                            && (CW'(run_ff) >= CW'(cnt_ff));
               rsp_valid_in = 1'b1;
               if (!full) begin
                  fill_in = fill_ff + IDX_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      target_in = target_ff;
      count_in  = count_ff;
      gain_in   = gain_ff;
      if (csr_write) begin
         unique case (paddr)
            hgssd_pkg::ADDR_TARGET: target_in = pwdata[hgssd_pkg::HUE_W-1:0];
            hgssd_pkg::ADDR_COUNT:  count_in  = pwdata[hgssd_pkg::CNT_W-1:0];
            hgssd_pkg::ADDR_GAIN:   gain_in   = pwdata[hgssd_pkg::GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr)
         hgssd_pkg::ADDR_TARGET:
            prdata = {{(hgssd_pkg::DATA_W - hgssd_pkg::HUE_W){1'b0}}, target_ff};
         hgssd_pkg::ADDR_COUNT:
            prdata = {{(hgssd_pkg::DATA_W - hgssd_pkg::CNT_W){1'b0}}, count_ff};
         hgssd_pkg::ADDR_GAIN:
            prdata = {{(hgssd_pkg::DATA_W - hgssd_pkg::GAIN_W){1'b0}}, gain_ff};
         default:
            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         run_ff       <= '0;
         min_ff       <= '1;
         rsp_valid_ff <= 1'b0;
         target_ff    <= hgssd_pkg::TARGET_RST;
         count_ff     <= hgssd_pkg::COUNT_RST;
         gain_ff      <= hgssd_pkg::GAIN_RST;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         run_ff       <= run_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
         target_ff    <= target_in;
         count_ff     <= count_in;
         gain_ff      <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      found_ff <= found_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_surge_found = found_ff;

   a_accept_starts_sum: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_SUM)
      else $error("accepted request did not start the sum pass");

   a_result_from_cmp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_CMP)
      else $error("result raised outside the compare step");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> fill_ff <= cnt_ff)
      else $error("fill index beyond window length while busy");

   a_min_monotone: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> min_ff <= $past(min_ff))
      else $error("minimum sum increased");

endmodule
